@@ design/bse_pkg.sv @@
package bse_pkg;

  // Flags that travel with every result of a run.
  typedef struct packed {
    logic final_res;
    logic overflowed;
  } res_flags_t;

endpackage

@@ design/bubble_sort_early_exit.sv @@
// Bubble sorter with early exit, built around one key memory.
//
// Input: a key is transferred at a rising edge with start high and busy low.
// Keys are stored in arrival order, up to DEPTH of them.
// Further keys are dropped and the run is marked as overflowed. The key
// with in_last high closes the set, and busy rises at once.
// Sorting: bubble passes run through the memory, one compare-swap per cycle.
// The passes shrink by one entry each and stop after a pass with no swap
// or after the pass over entries 0..1.
// Output: the n keys leave in ascending order on consecutive cycles,
// each marked by out_valid. The last carries out_final_res, and every one
// carries out_overflowed. The first result follows the closing key once
// the sort is done, via the EMIT read. busy falls on the last result's cycle.
// The receiver cannot stall: each result is on the ports for one cycle.
// Reset empties the set and clears the drop flag. Memory contents are
// left as they are, since only entries written in the current run are read.
module bubble_sort_early_exit #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic                in_last,
  output logic                out_valid,
  output logic [KEY_BITS-1:0] out_sorted_key,
  output logic                out_final_res,
  output logic                out_overflowed
);
  import bse_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // LOAD: collecting keys. FIRST/PRIME: start a pass. PASS: compare-swap.
  // TAIL: write back the carried key. EMIT: read out in order.
  typedef enum logic [2:0] {
    S_LOAD, S_FIRST, S_PRIME, S_PASS, S_TAIL, S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                drop_r, drop_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;        // entry held in rd_data_r
  logic [IDX_W-1:0]    pass_end_r, pass_end_nxt;
  logic                swapped_r, swapped_nxt;
  logic [KEY_BITS-1:0] carry_r, carry_nxt;    // largest key seen this pass
  logic                out_valid_r, out_valid_nxt;
  res_flags_t          flags_r, flags_nxt;

  // Memory ports
  logic [KEY_BITS-1:0] key_mem [DEPTH];
  logic [KEY_BITS-1:0] rd_data_r;
  logic                rd_en, wr_en;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  logic                take;
  logic                room;
  logic [CNT_W-1:0]    count_after;
  logic                swap;
  logic [IDX_W-1:0]    last_idx;

  assign busy      = (state_r != S_LOAD);
  assign take      = start && !busy;
  assign room      = (count_r < CNT_W'(DEPTH));
  assign count_after = count_r + CNT_W'(room);
  assign swap      = (carry_r > rd_data_r);
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    pos_nxt       = pos_r;
    pass_end_nxt  = pass_end_r;
    swapped_nxt   = swapped_r;
    carry_nxt     = carry_r;
    out_valid_nxt = 1'b0;
    flags_nxt     = flags_r;
    rd_en         = 1'b0;
    rd_addr       = pos_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data       = in_key;

    case (state_r)
      S_LOAD: begin
        if (take) begin
          if (room) begin
            wr_en     = 1'b1;
            count_nxt = count_after;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            pos_nxt = '0;
            if (count_after < CNT_W'(2)) begin
              state_nxt = S_EMIT;
            end else begin
              pass_end_nxt = IDX_W'(count_after - CNT_W'(1));
              state_nxt    = S_FIRST;
            end
          end
        end
      end
      S_FIRST: begin
        rd_en       = 1'b1;
        rd_addr     = '0;
        swapped_nxt = 1'b0;
        state_nxt   = S_PRIME;
      end
      S_PRIME: begin
        // entry 0 arrives; fetch entry 1
        carry_nxt = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = IDX_W'(1);
        pos_nxt   = IDX_W'(1);
        state_nxt = S_PASS;
      end
      S_PASS: begin
        // smaller of the pair drops into pos-1, larger is carried on
        wr_en   = 1'b1;
        wr_addr = pos_r - IDX_W'(1);
        wr_data = swap ? rd_data_r : carry_r;
        if (swap) begin
          swapped_nxt = 1'b1;
        end else begin
          carry_nxt = rd_data_r;
        end
        if (pos_r == pass_end_r) begin
          state_nxt = S_TAIL;
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos_r + IDX_W'(1);
          pos_nxt = pos_r + IDX_W'(1);
        end
      end
      S_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = pass_end_r;
        wr_data = carry_r;
        if (!swapped_r || pass_end_r == IDX_W'(1)) begin
          pos_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          pass_end_nxt = pass_end_r - IDX_W'(1);
          state_nxt    = S_FIRST;
        end
      end
      S_EMIT: begin
        rd_en                = 1'b1;
        rd_addr              = pos_r;
        out_valid_nxt        = 1'b1;
        flags_nxt.final_res  = (pos_r == last_idx);
        flags_nxt.overflowed = drop_r;
        if (pos_r == last_idx) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          pos_nxt = pos_r + IDX_W'(1);
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      swapped_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      swapped_r   <= swapped_nxt;
    end
    pos_r      <= pos_nxt;
    pass_end_r <= pass_end_nxt;
    carry_r    <= carry_nxt;
    flags_r    <= flags_nxt;
  end

  // Key memory: one write port, one read port, registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= key_mem[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_key = rd_data_r;
  assign out_final_res  = flags_r.final_res;
  assign out_overflowed = flags_r.overflowed;

  a_out_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EMIT))
    else $error("result strobe without read-out");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("key count beyond capacity");

  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PASS |-> (pos_r != '0) && (pos_r <= pass_end_r))
    else $error("pass position out of range");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write to the same entry");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_res) |-> (state_r == S_LOAD))
    else $error("final result while still busy");

endmodule
